>>> sv/periodic_timer_table_unit_defines.svh
// Assertion macros for the top-level file that checks this block.
`ifndef PERIODIC_TIMER_TABLE_UNIT_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PTTU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PTTU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PTTU_ASSERT_IMP(lbl, ante, cons, msg)
`define PTTU_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> sv/pttu_pkg.sv
package pttu_pkg;

  localparam int SLOTS_DEF = 8;

  localparam int EVENT_W  = 8;
  localparam int PERIOD_W = 16;

  // slot entry: countdown lowest, then reload, then event id
  localparam int CD_LO  = 0;
  localparam int RLD_LO = PERIOD_W;
  localparam int EV_LO  = 2 * PERIOD_W;
  localparam int ENTRY_W = EVENT_W + 2 * PERIOD_W;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_FIRED = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic latch_in;   // capture event id and period of the accepted word
    logic add_do;     // store the timer if there is room and push the reply
    logic idx_clr;    // restart the slot sweep
    logic rd_en;      // read the slot under the sweep index
    logic tick_wr;    // write back the decremented or reloaded countdown
    logic idx_inc;    // advance the sweep index
    logic pend_set;   // hold the current slot's event as the pending firing
    logic push_mid;   // push the pending firing, not last
    logic push_last;  // push the pending firing, last
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;      // no slot in use
    logic idx_last;   // sweep index sits on the highest used slot
    logic fire;       // slot just read expires on this tick
    logic pend_valid; // a firing is held back for its last marker
    logic out_free;   // output register can take a word this cycle
  } sts_t;

endpackage

>>> sv/pttu_ram.sv
module pttu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/pttu_ctrl.sv
module pttu_ctrl
  import pttu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_op,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADD   = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_CHK   = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          if (in_op == OP_ADD) begin
            state_nxt = ST_ADD;
          end else if (!sts.empty) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = ST_RD;
          end
        end
      end
      ST_ADD: begin
        if (sts.out_free) begin
          cmd.add_do = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        // hold while a second firing needs the output and it is busy
        if (!(sts.fire && sts.pend_valid && !sts.out_free)) begin
          cmd.tick_wr  = 1'b1;
          cmd.idx_inc  = 1'b1;
          cmd.pend_set = sts.fire;
          cmd.push_mid = sts.fire && sts.pend_valid;
          state_nxt    = sts.idx_last ? ST_FLUSH : ST_RD;
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.push_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/pttu_dp.sv
module pttu_dp
  import pttu_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [EVENT_W-1:0]  in_ev_r;
  logic [PERIOD_W-1:0] in_per_r;
  logic                pend_valid_r, pend_valid_nxt;
  logic [EVENT_W-1:0]  pend_ev_r;
  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r, out_acc_r, out_last_r;
  logic [EVENT_W-1:0]  out_ev_r;

  logic                full;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [ENTRY_W-1:0]  wr_data;
  logic [ENTRY_W-1:0]  rd_data;
  logic [PERIOD_W-1:0] rd_cd, rd_rld, cd_dec;
  logic [EVENT_W-1:0]  rd_ev;
  logic                out_free;

  assign full   = (used_r == CNT_W'(SLOTS));
  assign rd_cd  = rd_data[CD_LO +: PERIOD_W];
  assign rd_rld = rd_data[RLD_LO +: PERIOD_W];
  assign rd_ev  = rd_data[EV_LO +: EVENT_W];
  assign cd_dec = rd_cd - PERIOD_W'(1);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = {rd_ev, rd_rld, (cd_dec == '0) ? rd_rld : cd_dec};
    if (cmd.add_do) begin
      wr_en   = !full;
      wr_addr = used_r[IDX_W-1:0];
      wr_data = {in_ev_r, in_per_r, in_per_r};
    end else if (cmd.tick_wr) begin
      wr_en = 1'b1;
    end
  end

  pttu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  always_comb begin
    used_nxt = used_r;
    if (cmd.add_do && !full) begin
      used_nxt = used_r + CNT_W'(1);
    end
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc && !sts.idx_last) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    pend_valid_nxt = pend_valid_r;
    if (cmd.pend_set) begin
      pend_valid_nxt = 1'b1;
    end else if (cmd.push_last) begin
      pend_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (cmd.add_do || cmd.push_mid || cmd.push_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      idx_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      used_r       <= used_nxt;
      idx_r        <= idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_ev_r  <= in_tdata[EVENT_W-1:0];
      in_per_r <= in_tdata[EVENT_W +: PERIOD_W];
    end
    if (cmd.pend_set) begin
      pend_ev_r <= rd_ev;
    end
    if (cmd.add_do) begin
      out_kind_r <= KIND_REPLY;
      out_acc_r  <= !full;
      out_ev_r   <= '0;
      out_last_r <= 1'b1;
    end else if (cmd.push_mid || cmd.push_last) begin
      out_kind_r <= KIND_FIRED;
      out_acc_r  <= 1'b0;
      out_ev_r   <= pend_ev_r;
      out_last_r <= cmd.push_last;
    end
  end

  assign sts.empty      = (used_r == '0);
  assign sts.idx_last   = ((CNT_W'(idx_r) + CNT_W'(1)) == used_r);
  assign sts.fire       = (cd_dec == '0);
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_free   = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W - EVENT_W - 1){1'b0}}, out_ev_r, out_acc_r};

endmodule

>>> sv/periodic_timer_table_unit.sv
// Add: the ADD state loads the reply word into the output register once that is free.
// Tick: each used slot is read (RD), then its countdown written back (CHK), between IDLE
// and FLUSH; an empty table stays in IDLE. A busy output register stalls the sweep. A firing
// is held until the next firing or the sweep's end, so its last marker is known before it
// goes out. Reset (rst_n low, synchronous) empties the table and clears the controller and
// output register; slot contents are only read once written.
`include "periodic_timer_table_unit_defines.svh"

module periodic_timer_table_unit
  import pttu_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input words
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] ev_id, [23:8] period
  input  logic                   in_tuser,   // op: 0 add timer, 1 tick
  // result words
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] accepted, [8:1] fired_event, rest zero
  output logic                   out_tuser,  // kind: 0 add reply, 1 fired event
  output logic                   out_tlast   // last word caused by the input word
);

  cmd_t cmd;
  sts_t sts;

  // Controller: sequence one input word at a time - add, or sweep the used slots on a tick.
  pttu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: slot RAM, fill count, sweep index, pending firing and output register.
  pttu_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Never push more than one word into the output register in a cycle.
  `PTTU_ASSERT_IMP(a_one_push, 1'b1,
                   $onehot0({cmd.add_do, cmd.push_mid, cmd.push_last}),
                   "pttu: more than one push in a cycle")
  // Push only when the output register is free, so no word is overwritten.
  `PTTU_ASSERT_IMP(a_push_free, cmd.add_do || cmd.push_mid || cmd.push_last,
                   sts.out_free, "pttu: push into a busy output register")
  // Drop the pending firing once it goes out with its last marker.
  `PTTU_ASSERT_NXT(a_pend_clear, cmd.push_last, !sts.pend_valid,
                   "pttu: pending firing kept after last push")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench
  import pttu_pkg::*;
();

  localparam int SLOT_COUNT   = SLOTS_DEF;
  localparam int PAD_W        = OUT_TDATA_W - 1 - EVENT_W;
  // Allow ample margin after the last expected word for a full sweep to finish.
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_SHOWN    = 10;
  localparam int RANDOM_WORDS = 101;

  // One result word as seen on the master side, pad bits included.
  typedef struct packed {
    logic               kind;
    logic               accepted;
    logic [EVENT_W-1:0] fired_event;
    logic               last;
    logic [PAD_W-1:0]   pad;
  } result_word_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [7:0] ev_id, [23:8] period
  logic                   in_tuser   = 1'b0; // op
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [0] accepted, [8:1] fired_event
  logic                   out_tuser;         // kind
  logic                   out_tlast;

  // Own copy of the timer table, advanced on every accepted input word.
  int                     timers_used;
  logic [EVENT_W-1:0]     timer_event  [SLOT_COUNT];
  logic [PERIOD_W-1:0]    timer_reload [SLOT_COUNT];
  logic [PERIOD_W-1:0]    timer_count  [SLOT_COUNT];

  result_word_t           expected_results[$];
  int                     error_count   = 0;
  int                     send_gap_pct  = 0;
  int                     stall_pct     = 0;
  int                     cycle_count   = 0;

  periodic_timer_table_unit #(
    .SLOTS(SLOT_COUNT)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Work out the result words one accepted input word causes, and queue them.
  task automatic predict_timer_table(input logic op, input logic [EVENT_W-1:0] ev_id,
                                     input logic [PERIOD_W-1:0] per);
    result_word_t w;
    result_word_t burst[$];
    if (op == OP_ADD) begin
      w          = '0;
      w.kind     = KIND_REPLY;
      w.last     = 1'b1;
      // Store only while there is a free slot; a full table leaves state alone.
      if (timers_used < SLOT_COUNT) begin
        timer_event[timers_used]  = ev_id;
        timer_reload[timers_used] = per;
        timer_count[timers_used]  = per;
        timers_used++;
        w.accepted = 1'b1;
      end
      expected_results.push_back(w);
    end else begin
      // Decrement with 16-bit wrap, so a zero period lasts 65536 ticks.
      for (int i = 0; i < timers_used; i++) begin
        timer_count[i] = timer_count[i] - 1'b1;
        if (timer_count[i] == '0) begin
          timer_count[i] = timer_reload[i];
          w              = '0;
          w.kind         = KIND_FIRED;
          w.fired_event  = timer_event[i];
          burst.push_back(w);
        end
      end
      // Mark only the final firing of the sweep; a quiet tick yields nothing.
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[k]) expected_results.push_back(burst[k]);
    end
  endtask

  // Offer one input word, idling beforehand at the current rate, and hold it until taken.
  task automatic send_word(input logic op, input logic [EVENT_W-1:0] ev_id,
                           input logic [PERIOD_W-1:0] per);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {per, ev_id};
    do @(posedge clk); while (!in_tready);
    predict_timer_table(op, ev_id, per);
  endtask

  task automatic send_tick();
    send_word(OP_TICK, EVENT_W'($urandom), PERIOD_W'($urandom));
  endtask

  task automatic report_mismatch(input string what, input result_word_t want,
                                 input result_word_t got);
    error_count++;
    if (error_count <= MAX_SHOWN)
      $display("mismatch (%s): expected kind=%0b acc=%0b ev=%02h last=%0b pad=%0h, got kind=%0b acc=%0b ev=%02h last=%0b pad=%0h",
               what, want.kind, want.accepted, want.fired_event, want.last, want.pad,
               got.kind, got.accepted, got.fired_event, got.last, got.pad);
  endtask

  // Compare each accepted result word with the oldest expectation, then pick the next ready.
  always @(posedge clk) begin : check_results
    result_word_t got;
    result_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind        = out_tuser;
      got.accepted    = out_tdata[0];
      got.fired_event = out_tdata[EVENT_W:1];
      got.last        = out_tlast;
      got.pad         = out_tdata[OUT_TDATA_W-1:EVENT_W+1];
      if (expected_results.size() == 0) begin
        report_mismatch("no word expected", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) report_mismatch("field", want, got);
      end
    end
    out_tready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // Hard stop should the block hang.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // A tick on an empty table must give no word at all.
  task automatic test_empty_tick();
    send_tick();
  endtask

  // Highest event id with the shortest period: fires on every tick.
  task automatic test_first_timer();
    send_word(OP_ADD, 8'hFF, 16'd1);
    send_tick();
  endtask

  // Zero period wraps to 65535 on its first tick and stays quiet.
  task automatic test_zero_period();
    send_word(OP_ADD, 8'h00, 16'd0);
    send_tick();
  endtask

  // Fill the remaining slots, the longest period among them.
  task automatic test_fill_table();
    send_word(OP_ADD, 8'h5A, 16'hFFFF);
    send_word(OP_ADD, 8'h01, 16'd2);
    send_word(OP_ADD, 8'h80, 16'd3);
    send_word(OP_ADD, 8'h7E, 16'd1);
    send_word(OP_ADD, 8'hC3, 16'd4);
    send_word(OP_ADD, 8'h3C, 16'd6);
  endtask

  // Adds beyond the last slot are rejected without touching the table.
  task automatic test_table_full();
    send_word(OP_ADD, 8'h11, 16'h1234);
    send_word(OP_ADD, 8'hEE, 16'h0001);
  endtask

  // Periods 1, 2, 3, 4 and 6 line up on the twelfth tick: six firings in one sweep.
  task automatic test_multi_fire();
    repeat (12) send_tick();
  endtask

  // Mostly ticks with random payload, the rest adds that the full table turns away.
  task automatic test_random_traffic(input int n_words, input int gap_pct, input int stall);
    send_gap_pct = gap_pct;
    stall_pct    = stall;
    repeat (n_words) begin
      if ($urandom_range(99) < 75) send_tick();
      else send_word(OP_ADD, EVENT_W'($urandom), PERIOD_W'($urandom));
    end
  endtask

  initial begin
    timers_used = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_tick();
    test_first_timer();
    test_zero_period();
    test_fill_table();
    test_table_full();
    test_multi_fire();

    test_random_traffic(RANDOM_WORDS, 0, 0);
    test_random_traffic(RANDOM_WORDS, 57, 0);
    test_random_traffic(RANDOM_WORDS, 0, 57);
    test_random_traffic(RANDOM_WORDS, 26, 26);

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
